// ===== sv/line_editor_field_tokenizer_top_assert.svh =====
// Assertion macros used by the tokenizer back end.
`ifndef LINE_EDITOR_FIELD_TOKENIZER_TOP_ASSERT_SVH
`define LINE_EDITOR_FIELD_TOKENIZER_TOP_ASSERT_SVH

// same-cycle implication
`define LFT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lft: same-cycle check failed");

// next-cycle implication
`define LFT_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lft: next-cycle check failed");

`endif

// ===== sv/lft_pkg.sv =====
package lft_pkg;

  localparam int LINE_MAX_DEF   = 80;
  localparam int FIELDS_MAX_DEF = 5;
  // command address width, enough for any line length up to 255
  localparam int CMD_AW         = 8;
  localparam int Q_DEPTH        = 2;

  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_DEL   = 8'd127;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_LA    = 8'd97;
  localparam logic [7:0] CH_LZ    = 8'd122;
  localparam logic [7:0] CH_UA    = 8'd65;
  localparam logic [7:0] CH_UZ    = 8'd90;
  localparam logic [7:0] CH_D0    = 8'd48;
  localparam logic [7:0] CH_D9    = 8'd57;

  typedef enum logic [1:0] {
    KIND_ECHO  = 2'd0,
    KIND_FIELD = 2'd1,
    KIND_END   = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    OP_READ  = 3'd0,
    OP_RNUL  = 3'd1,
    OP_ECHO  = 3'd2,
    OP_LIMIT = 3'd3,
    OP_CR    = 3'd4
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [7:0]       data;
    logic [CMD_AW-1:0] addr;
  } cmd_t;

endpackage

// ===== sv/lft_ram.sv =====
module lft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 81
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/lft_front.sv =====
module lft_front #(
  parameter int LINE_MAX = lft_pkg::LINE_MAX_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         accept,
  input  logic         action,
  input  logic [7:0]   rx_byte,
  input  logic [6:0]   read_address,
  output logic         q_push,
  output lft_pkg::cmd_t q_cmd
);

  import lft_pkg::*;

  localparam int PW = $clog2(LINE_MAX + 1);

  logic [PW-1:0] char_count;
  logic [PW-1:0] char_count_next;

  always_comb begin
    char_count_next = char_count;
    q_push          = 1'b0;
    q_cmd.op        = OP_READ;
    q_cmd.data      = rx_byte;
    q_cmd.addr      = CMD_AW'(read_address);
    if (accept) begin
      if (action) begin
        q_push   = 1'b1;
        q_cmd.op = (int'(read_address) <= LINE_MAX) ? OP_READ : OP_RNUL;
      end else begin
        priority if (rx_byte == CH_BS || rx_byte == CH_DEL) begin
          if (char_count != '0) begin
            char_count_next = char_count - PW'(1);
          end
        end else if (rx_byte == CH_CR) begin
          q_push          = 1'b1;
          q_cmd.op        = OP_CR;
          q_cmd.addr      = CMD_AW'(char_count);
          char_count_next = '0;
        end else if (rx_byte >= CH_SPACE) begin
          q_push     = 1'b1;
          q_cmd.addr = CMD_AW'(char_count);
          // last free slot: this character closes the line
          if (char_count == PW'(LINE_MAX - 1)) begin
            q_cmd.op        = OP_LIMIT;
            char_count_next = '0;
          end else begin
            q_cmd.op        = OP_ECHO;
            char_count_next = char_count + PW'(1);
          end
        end else begin
          char_count_next = char_count;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count <= '0;
    end else begin
      char_count <= char_count_next;
    end
  end

endmodule

// ===== sv/lft_queue.sv =====
module lft_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lft_pkg::cmd_t cmd_in,
  input  logic          pop,
  output logic          full,
  output logic          valid,
  output lft_pkg::cmd_t cmd_out
);

  import lft_pkg::*;

  localparam int DEPTH = Q_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  cmd_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == CW'(DEPTH));
  assign valid   = (count != '0);
  assign cmd_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/lft_back.sv =====
`include "line_editor_field_tokenizer_top_assert.svh"

module lft_back #(
  parameter int LINE_MAX   = lft_pkg::LINE_MAX_DEF,
  parameter int FIELDS_MAX = lft_pkg::FIELDS_MAX_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  lft_pkg::cmd_t q_cmd,
  output logic          q_pop,
  input  logic          pop,
  output logic          empty,
  output logic [1:0]    kind,
  output logic [7:0]    data_byte,
  output logic [2:0]    field_index,
  output logic          field_type,
  output logic [6:0]    field_position,
  output logic [2:0]    field_count,
  output logic          last
);

  import lft_pkg::*;

  localparam int PW = $clog2(LINE_MAX + 1);
  localparam int FW = $clog2(FIELDS_MAX + 1);

  typedef enum logic [7:0] {
    B_IDLE  = 8'b0000_0001,
    B_READ  = 8'b0000_0010,
    B_TERM  = 8'b0000_0100,
    B_ECHO  = 8'b0000_1000,
    B_ECHOE = 8'b0001_0000,
    B_SRD   = 8'b0010_0000,
    B_SEVAL = 8'b0100_0000,
    B_END   = 8'b1000_0000
  } state_t;

  typedef enum logic [1:0] {
    RUN_NONE  = 2'd0,
    RUN_ALPHA = 2'd1,
    RUN_DIGIT = 2'd2
  } run_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_D0 && c <= CH_D9;
  endfunction

  state_t        state, state_next;
  cmd_t          cmd, cmd_next;
  logic [PW-1:0] term_addr, term_addr_next;
  logic [PW-1:0] scan_idx, scan_idx_next;
  logic [FW-1:0] fields_found, fields_found_next;
  run_t          prev, prev_next;

  logic          we, re;
  logic [PW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;

  logic          can_emit, emit;
  kind_t         res_kind;
  logic [7:0]    res_data;
  logic [2:0]    res_idx;
  logic          res_type;
  logic [6:0]    res_pos;
  logic [2:0]    res_cnt;
  logic          res_last;

  logic          out_valid;
  kind_t         out_kind;
  logic [7:0]    out_data;
  logic [2:0]    out_idx;
  logic          out_type;
  logic [6:0]    out_pos;
  logic [2:0]    out_cnt;
  logic          out_last;

  logic          c_alpha, c_digit;

  lft_ram #(
    .WIDTH (8),
    .DEPTH (LINE_MAX + 1)
  ) u_line_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign can_emit = !out_valid || pop;
  assign c_alpha  = is_alpha(rdata);
  assign c_digit  = is_digit(rdata);

  always_comb begin
    state_next        = state;
    cmd_next          = cmd;
    term_addr_next    = term_addr;
    scan_idx_next     = scan_idx;
    fields_found_next = fields_found;
    prev_next         = prev;
    q_pop             = 1'b0;
    we                = 1'b0;
    waddr             = PW'(cmd.addr);
    wdata             = cmd.data;
    re                = 1'b0;
    raddr             = PW'(cmd.addr);
    emit              = 1'b0;
    res_kind          = KIND_ECHO;
    res_data          = '0;
    res_idx           = '0;
    res_type          = 1'b0;
    res_pos           = '0;
    res_cnt           = '0;
    res_last          = 1'b0;

    unique case (state)
      B_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          cmd_next = q_cmd;
          unique case (q_cmd.op)
            OP_READ: begin
              re         = 1'b1;
              raddr      = PW'(q_cmd.addr);
              state_next = B_READ;
            end
            OP_RNUL: state_next = B_READ;
            OP_ECHO: begin
              we         = 1'b1;
              waddr      = PW'(q_cmd.addr);
              wdata      = q_cmd.data;
              state_next = B_ECHO;
            end
            OP_LIMIT: begin
              we             = 1'b1;
              waddr          = PW'(q_cmd.addr);
              wdata          = q_cmd.data;
              term_addr_next = PW'(q_cmd.addr) + PW'(1);
              state_next     = B_TERM;
            end
            OP_CR: begin
              term_addr_next = PW'(q_cmd.addr);
              state_next     = B_TERM;
            end
            default: state_next = B_IDLE;
          endcase
        end
      end
      B_READ: begin
        if (can_emit) begin
          emit       = 1'b1;
          res_kind   = KIND_READ;
          res_data   = (cmd.op == OP_READ) ? rdata : 8'd0;
          res_last   = 1'b1;
          state_next = B_IDLE;
        end
      end
      B_TERM: begin
        we         = 1'b1;
        waddr      = term_addr;
        wdata      = 8'd0;
        state_next = B_ECHOE;
      end
      B_ECHO: begin
        if (can_emit) begin
          emit       = 1'b1;
          res_data   = cmd.data;
          res_last   = 1'b1;
          state_next = B_IDLE;
        end
      end
      B_ECHOE: begin
        if (can_emit) begin
          emit              = 1'b1;
          res_data          = cmd.data;
          scan_idx_next     = '0;
          fields_found_next = '0;
          prev_next         = RUN_NONE;
          state_next        = B_SRD;
        end
      end
      B_SRD: begin
        if (int'(fields_found) >= FIELDS_MAX) begin
          state_next = B_END;
        end else begin
          re         = 1'b1;
          raddr      = scan_idx;
          state_next = B_SEVAL;
        end
      end
      B_SEVAL: begin
        // rdata holds the character at scan_idx until the next read
        priority if (rdata == 8'd0) begin
          state_next = B_END;
        end else if (c_alpha && prev != RUN_ALPHA) begin
          if (can_emit) begin
            emit              = 1'b1;
            res_kind          = KIND_FIELD;
            res_idx           = 3'(fields_found);
            res_pos           = 7'(scan_idx);
            prev_next         = RUN_ALPHA;
            fields_found_next = fields_found + FW'(1);
            scan_idx_next     = scan_idx + PW'(1);
            state_next        = B_SRD;
          end
        end else if (c_digit && prev != RUN_DIGIT) begin
          if (can_emit) begin
            emit              = 1'b1;
            res_kind          = KIND_FIELD;
            res_idx           = 3'(fields_found);
            res_type          = 1'b1;
            res_pos           = 7'(scan_idx);
            prev_next         = RUN_DIGIT;
            fields_found_next = fields_found + FW'(1);
            scan_idx_next     = scan_idx + PW'(1);
            state_next        = B_SRD;
          end
        end else if (!c_alpha && !c_digit) begin
          // separator: blank it out in the store
          we            = 1'b1;
          waddr         = scan_idx;
          wdata         = 8'd0;
          prev_next     = RUN_NONE;
          scan_idx_next = scan_idx + PW'(1);
          state_next    = B_SRD;
        end else begin
          scan_idx_next = scan_idx + PW'(1);
          state_next    = B_SRD;
        end
      end
      B_END: begin
        if (can_emit) begin
          emit       = 1'b1;
          res_kind   = KIND_END;
          res_cnt    = 3'(fields_found);
          res_last   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      scan_idx     <= '0;
      fields_found <= '0;
      prev         <= RUN_NONE;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      scan_idx     <= scan_idx_next;
      fields_found <= fields_found_next;
      prev         <= prev_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd       <= cmd_next;
    term_addr <= term_addr_next;
    if (emit) begin
      out_kind <= res_kind;
      out_data <= res_data;
      out_idx  <= res_idx;
      out_type <= res_type;
      out_pos  <= res_pos;
      out_cnt  <= res_cnt;
      out_last <= res_last;
    end
  end

  assign empty          = !out_valid;
  assign kind           = out_kind;
  assign data_byte      = out_data;
  assign field_index    = out_idx;
  assign field_type     = out_type;
  assign field_position = out_pos;
  assign field_count    = out_cnt;
  assign last           = out_last;

  `LFT_ASSERT_IMP(a_pop_has_word, clk, rst, q_pop, q_valid)
  `LFT_ASSERT_IMP(a_no_overwrite, clk, rst, emit, !out_valid || pop)
  `LFT_ASSERT_IMP(a_scan_in_store, clk, rst, state == B_SEVAL, int'(scan_idx) <= LINE_MAX)
  `LFT_ASSERT_NXT(a_end_is_last, clk, rst, state == B_END && can_emit, out_valid && out_last)

endmodule

// ===== sv/line_editor_field_tokenizer_top.sv =====
// An echo or read word passes through the queue, then the IDLE and ECHO or READ states.
// Line end: IDLE, TERM (terminator write), ECHOE (echo), then SRD and SEVAL (read, evaluate)
// per character up to the terminator or the field limit, then END emits the end word.
// The back sequencer finishes each command before it pops the next one from the queue.
// Reset (rst, synchronous, active high) clears the character count, queue and sequencer;
// the line store keeps its contents and needs no clearing pass.
module line_editor_field_tokenizer_top #(
  parameter int LINE_MAX   = lft_pkg::LINE_MAX_DEF,
  parameter int FIELDS_MAX = lft_pkg::FIELDS_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       action,
  input  logic [7:0] rx_byte,
  input  logic [6:0] read_address,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] kind,
  output logic [7:0] data_byte,
  output logic [2:0] field_index,
  output logic       field_type,
  output logic [6:0] field_position,
  output logic [2:0] field_count,
  output logic       last
);

  import lft_pkg::*;

  logic accept;
  logic q_push, q_full, q_valid, q_pop;
  cmd_t q_in, q_out;

  assign full   = q_full;
  assign accept = push && !q_full;

  lft_front #(
    .LINE_MAX (LINE_MAX)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .action       (action),
    .rx_byte      (rx_byte),
    .read_address (read_address),
    .q_push       (q_push),
    .q_cmd        (q_in)
  );

  lft_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .cmd_in  (q_in),
    .pop     (q_pop),
    .full    (q_full),
    .valid   (q_valid),
    .cmd_out (q_out)
  );

  lft_back #(
    .LINE_MAX   (LINE_MAX),
    .FIELDS_MAX (FIELDS_MAX)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_cmd          (q_out),
    .q_pop          (q_pop),
    .pop            (pop),
    .empty          (empty),
    .kind           (kind),
    .data_byte      (data_byte),
    .field_index    (field_index),
    .field_type     (field_type),
    .field_position (field_position),
    .field_count    (field_count),
    .last           (last)
  );

endmodule
